// ----- sv/mfx_pkg.sv -----
// ----------------------------------------------------------------------------
// Max filter 3x3 package
// Shared widths, reset values, register codes and the record types that pass
// between the front end, the job queue and the output stage.
// ----------------------------------------------------------------------------
package mfx_pkg;

    localparam int MAX_WIDTH_DEF   = 1024;
    localparam int PIX_BITS        = 8;
    localparam int ROW_BITS        = 16;
    localparam int COL_OUT_BITS    = 10;
    localparam int CFG_WIDTH_BITS  = 11;
    localparam int CFG_HEIGHT_BITS = 16;
    localparam int CFG_DATA_BITS   = 16;

    localparam int QUEUE_DEPTH     = 4;
    localparam int QUEUE_PTR_BITS  = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_BITS  = $clog2(QUEUE_DEPTH + 1);

    localparam logic [CFG_WIDTH_BITS-1:0]  WIDTH_RESET  = 11'd15;
    localparam logic [CFG_HEIGHT_BITS-1:0] HEIGHT_RESET = 16'd10;

    typedef enum logic {
        CFG_IMAGE_WIDTH  = 1'b0,
        CFG_IMAGE_HEIGHT = 1'b1
    } t_cfg_idx;

    typedef logic [PIX_BITS-1:0] t_pixel;

    typedef struct packed {
        logic                    has_max;
        logic                    border;
        logic                    done;
        logic [ROW_BITS-1:0]     row;
        logic [COL_OUT_BITS-1:0] col;
        t_pixel                  max_value;
        t_pixel                  pixel;
    } t_job;

    typedef struct packed {
        logic                      empty;
        logic [QUEUE_CNT_BITS-1:0] count;
    } t_queue_status;

endpackage

// ----- sv/mfx_stream_if.sv -----
// ----------------------------------------------------------------------------
// Max filter 3x3 stream interfaces
// Valid/ready channels for incoming pixels and for filtered results.
// ----------------------------------------------------------------------------
interface mfx_pix_if import mfx_pkg::*; ();
    logic   valid;
    logic   ready;
    t_pixel pixel;

    modport source (output valid, output pixel, input ready);
    modport sink   (input valid, input pixel, output ready);
endinterface

interface mfx_res_if import mfx_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic [ROW_BITS-1:0]     out_row;
    logic [COL_OUT_BITS-1:0] out_col;
    t_pixel                  out_value;
    logic                    run_last;
    logic                    frame_done;

    modport source (output valid, output out_row, output out_col, output out_value,
                    output run_last, output frame_done, input ready);
    modport sink   (input valid, input out_row, input out_col, input out_value,
                    input run_last, input frame_done, output ready);
endinterface

// ----- sv/mfx_front.sv -----
// ----------------------------------------------------------------------------
// Max filter 3x3 front end
// Accepts pixels, tracks row and column, keeps the two line buffers and the
// window, and turns every pixel that yields results into a job for the queue.
// ----------------------------------------------------------------------------
module mfx_front import mfx_pkg::*; #(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  t_cfg_idx                 i_cfg_idx,
    input  logic [CFG_DATA_BITS-1:0] i_cfg_data,
    mfx_pix_if.sink                  i_pix,
    input  t_queue_status            i_qstat,
    output logic                     o_push,
    output t_job                     o_job
);

    localparam int COL_BITS = $clog2(MAX_WIDTH);
    localparam int EW_BITS  = (CFG_WIDTH_BITS > $clog2(MAX_WIDTH + 1)) ?
                              CFG_WIDTH_BITS : $clog2(MAX_WIDTH + 1);
    localparam logic [EW_BITS-1:0] MAX_W = EW_BITS'(MAX_WIDTH);

    function automatic t_pixel max2(input t_pixel x, input t_pixel y);
        return (x > y) ? x : y;
    endfunction

    logic [CFG_WIDTH_BITS-1:0]  r_img_width;
    logic [CFG_HEIGHT_BITS-1:0] r_img_height;
    logic [ROW_BITS-1:0]        r_row;
    logic [COL_BITS-1:0]        r_col;

    t_pixel                     mem_two [MAX_WIDTH];
    t_pixel                     mem_one [MAX_WIDTH];

    logic                       r_a_valid;
    t_pixel                     r_a_pixel;
    t_pixel                     r_a_two;
    t_pixel                     r_a_one;
    logic [ROW_BITS-1:0]        r_a_row;
    logic [COL_BITS-1:0]        r_a_col;
    logic                       r_a_has_max;
    logic                       r_a_border;
    logic                       r_a_done;

    t_pixel                     r_win [3][2];

    logic [EW_BITS-1:0]         width_ext;
    logic [EW_BITS-1:0]         eff_width;
    logic [EW_BITS-1:0]         last_col_full;
    logic [COL_BITS-1:0]        last_col;
    logic [ROW_BITS-1:0]        last_row;
    logic                       at_last_col;
    logic                       at_last_row;
    logic [QUEUE_CNT_BITS:0]    used;
    logic                       accept;
    logic [COL_BITS+COL_OUT_BITS-1:0] col_ext;
    t_pixel                     m0, m1, m2, m3, m4, m5, m6, win_max;

    assign width_ext = EW_BITS'(r_img_width);

    always_comb begin
        if (width_ext == '0) begin
            eff_width = EW_BITS'(1);
        end else if (width_ext > MAX_W) begin
            eff_width = MAX_W;
        end else begin
            eff_width = width_ext;
        end
    end

    assign last_col_full = eff_width - EW_BITS'(1);
    assign last_col      = last_col_full[COL_BITS-1:0];
    assign last_row      = (r_img_height == '0) ? '0 : r_img_height - ROW_BITS'(1);
    assign at_last_col   = (r_col == last_col);
    assign at_last_row   = (r_row == last_row);

    // Room is reserved for the item sitting in the read stage.
    assign used        = {1'b0, i_qstat.count} + (QUEUE_CNT_BITS + 1)'(r_a_valid);
    assign i_pix.ready = (used < (QUEUE_CNT_BITS + 1)'(QUEUE_DEPTH));
    assign accept      = i_pix.valid & i_pix.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_img_width  <= WIDTH_RESET;
            r_img_height <= HEIGHT_RESET;
            r_row        <= '0;
            r_col        <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_IMAGE_WIDTH:  r_img_width  <= i_cfg_data[CFG_WIDTH_BITS-1:0];
                CFG_IMAGE_HEIGHT: r_img_height <= i_cfg_data[CFG_HEIGHT_BITS-1:0];
                default: ;
            endcase
            r_row <= '0;
            r_col <= '0;
        end else if (accept) begin
            if (at_last_col) begin
                r_col <= '0;
                r_row <= at_last_row ? '0 : r_row + ROW_BITS'(1);
            end else begin
                r_col <= r_col + COL_BITS'(1);
            end
        end
    end

    // The row two back is refreshed in the cycle after the read, from the old
    // content of the row one back.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_a_two          <= mem_two[r_col];
            r_a_one          <= mem_one[r_col];
            mem_one[r_col]   <= i_pix.pixel;
        end
        if (r_a_valid) begin
            mem_two[r_a_col] <= r_a_one;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else begin
            r_a_valid <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_a_pixel   <= i_pix.pixel;
            r_a_row     <= r_row;
            r_a_col     <= r_col;
            r_a_has_max <= (r_row >= ROW_BITS'(2)) && (r_col >= COL_BITS'(2));
            r_a_border  <= (r_row == '0) || at_last_row || (r_col == '0) || at_last_col;
            r_a_done    <= at_last_row && at_last_col;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 3; k++) begin
                r_win[k][0] <= '0;
                r_win[k][1] <= '0;
            end
        end else if (r_a_valid) begin
            for (int k = 0; k < 3; k++) begin
                r_win[k][0] <= r_win[k][1];
            end
            r_win[0][1] <= r_a_two;
            r_win[1][1] <= r_a_one;
            r_win[2][1] <= r_a_pixel;
        end
    end

    assign m0      = max2(r_win[0][0], r_win[0][1]);
    assign m1      = max2(r_win[1][0], r_win[1][1]);
    assign m2      = max2(r_win[2][0], r_win[2][1]);
    assign m3      = max2(r_a_two, r_a_one);
    assign m4      = max2(m0, m1);
    assign m5      = max2(m2, m3);
    assign m6      = max2(m4, m5);
    assign win_max = max2(m6, r_a_pixel);

    assign col_ext = {{COL_OUT_BITS{1'b0}}, r_a_col};

    assign o_push          = r_a_valid && (r_a_has_max || r_a_border);
    assign o_job.has_max   = r_a_has_max;
    assign o_job.border    = r_a_border;
    assign o_job.done      = r_a_done;
    assign o_job.row       = r_a_row;
    assign o_job.col       = col_ext[COL_OUT_BITS-1:0];
    assign o_job.max_value = win_max;
    assign o_job.pixel     = r_a_pixel;

endmodule

// ----- sv/mfx_queue.sv -----
// ----------------------------------------------------------------------------
// Max filter 3x3 job queue
// Small first-in first-out buffer of jobs between the front end and the
// output stage.
// ----------------------------------------------------------------------------
module mfx_queue import mfx_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  t_job          i_job,
    input  logic          i_pop,
    output t_job          o_head,
    output t_queue_status o_stat
);

    t_job                      r_mem [QUEUE_DEPTH];
    logic [QUEUE_PTR_BITS-1:0] r_wr_ptr;
    logic [QUEUE_PTR_BITS-1:0] r_rd_ptr;
    logic [QUEUE_CNT_BITS-1:0] r_count;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + QUEUE_PTR_BITS'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + QUEUE_PTR_BITS'(1);
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + QUEUE_CNT_BITS'(1);
                2'b01:   r_count <= r_count - QUEUE_CNT_BITS'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    assign o_head       = r_mem[r_rd_ptr];
    assign o_stat.empty = (r_count == '0);
    assign o_stat.count = r_count;

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (r_count != QUEUE_CNT_BITS'(QUEUE_DEPTH)) || i_pop)
        else $error("job queue written while full");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> (r_count != '0))
        else $error("job queue read while empty");

    a_ptr_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0) |-> (r_wr_ptr == r_rd_ptr))
        else $error("job queue pointers disagree with an empty count");

endmodule

// ----- sv/mfx_back.sv -----
// ----------------------------------------------------------------------------
// Max filter 3x3 output stage
// Expands each job into its window maximum and border copy results and holds
// them in an output register until the sink takes them.
// ----------------------------------------------------------------------------
module mfx_back import mfx_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_job          i_head,
    input  t_queue_status i_qstat,
    output logic          o_pop,
    mfx_res_if.source     o_res
);

    logic                    r_second;
    logic                    r_out_valid;
    logic [ROW_BITS-1:0]     r_row;
    logic [COL_OUT_BITS-1:0] r_col;
    t_pixel                  r_value;
    logic                    r_last;
    logic                    r_done;

    logic                    n_second;
    logic                    n_out_valid;
    logic                    load;
    logic                    have;
    logic                    sel_max;
    logic                    last;

    assign load = !r_out_valid || o_res.ready;
    assign have = !i_qstat.empty;

    always_comb begin
        o_pop       = 1'b0;
        n_second    = r_second;
        sel_max     = 1'b0;
        last        = 1'b1;
        n_out_valid = load ? have : r_out_valid;
        if (load && have) begin
            if (i_head.has_max && i_head.border && !r_second) begin
                sel_max  = 1'b1;
                last     = 1'b0;
                n_second = 1'b1;
            end else begin
                sel_max  = i_head.has_max && !r_second;
                o_pop    = 1'b1;
                n_second = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_second    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_second    <= n_second;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load && have) begin
            r_row   <= sel_max ? i_head.row - ROW_BITS'(1) : i_head.row;
            r_col   <= sel_max ? i_head.col - COL_OUT_BITS'(1) : i_head.col;
            r_value <= sel_max ? i_head.max_value : i_head.pixel;
            r_last  <= last;
            r_done  <= last && i_head.done;
        end
    end

    assign o_res.valid      = r_out_valid;
    assign o_res.out_row    = r_row;
    assign o_res.out_col    = r_col;
    assign o_res.out_value  = r_value;
    assign o_res.run_last   = r_last;
    assign o_res.frame_done = r_done;

    a_second_has_job: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_second |-> have && i_head.has_max && i_head.border)
        else $error("border copy pending without a matching job");

    a_second_after_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_second |-> r_out_valid)
        else $error("border copy pending while no maximum was issued");

    a_done_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_done) |-> r_last)
        else $error("frame end marked on a result that is not the last of its pixel");

endmodule

// ----- sv/max_filter_3x3_stream.sv -----
// ----------------------------------------------------------------------------
// A taken pixel passes the read stage, the job queue and the output register
// before its result appears. Throughput: one pixel per cycle while the sink is
// ready and pixels yield at most one result. A pixel with two results (right
// column or bottom row, past the first two) holds the output stage for both;
// the four-entry job queue absorbs a few of them, after which input is held back.
// Reset is synchronous: counters, window, queue and output clear, the image
// size returns to 15 by 10; the line buffers keep their content.
// ----------------------------------------------------------------------------
// Max filter 3x3 stream
// Raster-order 3x3 maximum filter with border pass-through and coordinates.
// ----------------------------------------------------------------------------
module max_filter_3x3_stream import mfx_pkg::*; #(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  t_cfg_idx                 i_cfg_idx,
    input  logic [CFG_DATA_BITS-1:0] i_cfg_data,
    mfx_pix_if.sink                  i_pix,
    mfx_res_if.source                o_res
);

    logic          push;
    logic          pop;
    t_job          job;
    t_job          head;
    t_queue_status qstat;

    mfx_front #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_pix      (i_pix),
        .i_qstat    (qstat),
        .o_push     (push),
        .o_job      (job)
    );

    mfx_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (job),
        .i_pop   (pop),
        .o_head  (head),
        .o_stat  (qstat)
    );

    mfx_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (head),
        .i_qstat (qstat),
        .o_pop   (pop),
        .o_res   (o_res)
    );

endmodule
